[rtl/sfna_pkg.sv]
// ----------------------------------------------------------------------------
// sfna_pkg
// Shared constants, codes and controller/datapath interface types for the
// lowest-free-number allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfna_pkg;

  // number range is 1 .. SIZE-1
  localparam int SIZE   = 1024;
  localparam int NUM_W  = 10;
  // free bitmap is held as rows of WORD_W bits
  localparam int WORD_W = 32;
  localparam int ROWS   = SIZE / WORD_W;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int BIT_W  = $clog2(WORD_W);

  typedef enum logic {
    CMD_POP = 1'b0,
    CMD_ADD = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RMW,
    ST_SCAN,
    ST_ADD_WR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic rd_lowest;   // read row of lowest free number, latch it as the pick
    logic rd_num;      // read row of the returned number, latch its bit index
    logic rd_next;     // read the next row up
    logic wr_clear;    // write back current row with picked bit cleared
    logic wr_set;      // write back current row with returned bit set
    logic mask_low;    // ignore bits at or below the picked bit
    logic set_hit;     // lowest free <= hit found in current row
    logic set_none;    // no free number left
    logic add_update;  // pointer update for an add-back
    logic emit_got;    // result: picked number
    logic emit_empty;  // result: empty
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic none_free;
    logic num_ok;
    logic hit;
    logic last_row;
  } sts_t;

endpackage

`default_nettype wire

[rtl/sfna_ram.sv]
// ----------------------------------------------------------------------------
// sfna_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfna_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/sfna_datapath.sv]
// ----------------------------------------------------------------------------
// sfna_datapath
// Free bitmap rows in RAM with per-row valid bits, lowest-free pointer,
// row scanner with priority encoder, and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sfna_datapath
  import sfna_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sfna_pkg::ctl_t        ctl_i,
  output sfna_pkg::sts_t             sts_o,
  input  wire logic [sfna_pkg::NUM_W-1:0] number_i,
  output logic [sfna_pkg::NUM_W-1:0] allocated_o,
  output logic                       empty_res_o,
  output logic                       valid_o
);

  logic [NUM_W-1:0]  lowest_q, lowest_d;
  logic              none_q, none_d;
  logic [NUM_W-1:0]  got_q;
  logic [BIT_W-1:0]  number_q;
  logic [ROW_W-1:0]  rd_row_q;
  logic [ROWS-1:0]   row_valid_q;
  logic [NUM_W-1:0]  alloc_q;
  logic              empty_q;
  logic              valid_q;

  logic              re;
  logic [ROW_W-1:0]  rd_addr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] eff_row;
  logic [WORD_W-1:0] scan_row;
  logic [WORD_W-1:0] wdata;
  logic              we;
  logic [BIT_W-1:0]  wr_bit;
  logic [BIT_W-1:0]  hit_idx;
  logic              hit;

  assign re = ctl_i.rd_lowest | ctl_i.rd_num | ctl_i.rd_next;
  assign we = ctl_i.wr_clear | ctl_i.wr_set;

  always_comb begin
    if (ctl_i.rd_lowest) begin
      rd_addr = lowest_q[BIT_W +: ROW_W];
    end else if (ctl_i.rd_num) begin
      rd_addr = number_i[BIT_W +: ROW_W];
    end else begin
      rd_addr = rd_row_q + ROW_W'(1);
    end
  end

  sfna_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (rd_row_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // a row never written reads as all free through its per-row valid bit
  assign eff_row = row_valid_q[rd_row_q] ? ram_rdata : '1;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      scan_row[i] = eff_row[i] & (!ctl_i.mask_low || (BIT_W'(i) > got_q[BIT_W-1:0]));
    end
  end

  // lowest set bit of the scanned row
  always_comb begin
    hit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (scan_row[i]) begin
        hit_idx = BIT_W'(i);
      end
    end
  end

  assign hit = |scan_row;

  always_comb begin
    wr_bit = ctl_i.wr_set ? number_q : got_q[BIT_W-1:0];
    wdata = eff_row;
    wdata[wr_bit] = ctl_i.wr_set;
  end

  always_comb begin
    lowest_d = lowest_q;
    none_d   = none_q;
    if (ctl_i.add_update) begin
      if (none_q || (number_i < lowest_q)) begin
        lowest_d = number_i;
        none_d   = 1'b0;
      end
    end else if (ctl_i.set_hit) begin
      lowest_d = NUM_W'({rd_row_q, hit_idx});
    end else if (ctl_i.set_none) begin
      none_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q    <= NUM_W'(1);
      none_q      <= 1'b0;
      row_valid_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      lowest_q <= lowest_d;
      none_q   <= none_d;
      if (we) begin
        row_valid_q[rd_row_q] <= 1'b1;
      end
      valid_q <= ctl_i.emit_got | ctl_i.emit_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_row_q <= rd_addr;
    end
    if (ctl_i.rd_lowest) begin
      got_q <= lowest_q;
    end
    if (ctl_i.rd_num) begin
      number_q <= number_i[BIT_W-1:0];
    end
    if (ctl_i.emit_got) begin
      alloc_q <= got_q;
      empty_q <= 1'b0;
    end else if (ctl_i.emit_empty) begin
      alloc_q <= '0;
      empty_q <= 1'b1;
    end
  end

  assign sts_o.none_free = none_q;
  assign sts_o.num_ok    = (number_i != '0) && (32'(number_i) < SIZE);
  assign sts_o.hit       = hit;
  assign sts_o.last_row  = (rd_row_q == ROW_W'(ROWS - 1));

  assign allocated_o = alloc_q;
  assign empty_res_o = empty_q;
  assign valid_o     = valid_q;

endmodule

`default_nettype wire

[rtl/sfna_ctrl.sv]
// ----------------------------------------------------------------------------
// sfna_ctrl
// Command sequencer: pop read-modify-write and upward row scan, add-back
// read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module sfna_ctrl
  import sfna_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic           command_i,
  input  wire sfna_pkg::sts_t sts_i,
  output sfna_pkg::ctl_t      ctl_o,
  output logic                busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_e'(command_i) == CMD_POP) begin
            if (sts_i.none_free) begin
              ctl_o.emit_empty = 1'b1;
            end else begin
              ctl_o.rd_lowest = 1'b1;
              state_d = ST_POP_RMW;
            end
          end else if (sts_i.num_ok) begin
            ctl_o.add_update = 1'b1;
            ctl_o.rd_num     = 1'b1;
            state_d = ST_ADD_WR;
          end
        end
      end
      ST_POP_RMW, ST_SCAN: begin
        ctl_o.wr_clear = (state_q == ST_POP_RMW);
        ctl_o.mask_low = (state_q == ST_POP_RMW);
        if (sts_i.hit) begin
          ctl_o.set_hit  = 1'b1;
          ctl_o.emit_got = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.last_row) begin
          ctl_o.set_none = 1'b1;
          ctl_o.emit_got = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ctl_o.rd_next = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_ADD_WR: begin
        ctl_o.wr_set = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[rtl/smallest_free_number_allocator.sv]
// ----------------------------------------------------------------------------
// smallest_free_number_allocator
// Hands out the lowest free number in 1..SIZE-1 and takes numbers back.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a rising edge with start high and busy low.
//   command_i = pop: the lowest free number comes out on allocated_o with
//   valid_o high for one cycle (empty_res_o high and allocated_o zero when
//   nothing is free). command_i = add: number_i is freed again; no result.
//   Add-back of zero or of a number at or above SIZE is dropped.
// Timing:
//   The free bitmap lives in a 32-row by 32-bit RAM with registered read.
//   A pop reads the picked row, clears the bit, then scans upward one row
//   per cycle with a priority encoder until a free bit is found or the top
//   row is reached. When its result shows depends on how many rows lie
//   between the picked number and the next free one. An empty pop answers
//   in the next cycle and keeps busy low. An add-back holds busy through
//   its write state; a dropped one leaves busy low.
// Reset:
//   All numbers are free and the lowest free is 1, right out of reset; rows
//   not yet written read as all free through per-row valid flops.
//   The receiver cannot stall: valid_o is a single-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module smallest_free_number_allocator
  import sfna_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       command_i,
  input  wire logic [sfna_pkg::NUM_W-1:0] number_i,
  output logic                            valid_o,
  output logic [sfna_pkg::NUM_W-1:0]      allocated_o,
  output logic                            empty_res_o
);

  ctl_t ctl;
  sts_t sts;

  sfna_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .busy      (busy)
  );

  sfna_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .number_i    (number_i),
    .allocated_o (allocated_o),
    .empty_res_o (empty_res_o),
    .valid_o     (valid_o)
  );

  // an empty result carries number zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && empty_res_o |-> allocated_o == '0)
    else $error("empty result with nonzero number");

  // a real allocation is never zero
  a_alloc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !empty_res_o |-> allocated_o != '0)
    else $error("allocated number zero");

  // an add-back transfer produces no result
  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == CMD_ADD |=> !valid_o)
    else $error("result after add-back");

  // a non-empty pop always leaves the controller busy
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == CMD_POP && !sts.none_free |=> busy)
    else $error("pop did not start a scan");

endmodule

`default_nettype wire
